// ----- src/tbc_pkg.sv -----
package tbc_pkg;

  // frame geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // field widths
  localparam int LUMA_W = 8;
  localparam int DIM_W  = 11;
  localparam int POS_W  = 10;
  localparam int CNT_W  = 21;
  localparam int SUM_W  = 30;

  // position counter widths
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_LUMA_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_DARK     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = CFG_IDX_W'(3);

  localparam logic [LUMA_W-1:0] RST_LUMA_THRESHOLD = LUMA_W'(128);
  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH    = DIM_W'(320);
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT   = DIM_W'(240);

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // divider: one quotient bit per cycle
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic             hit;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
    logic [SUM_W-1:0] sum_col;
    logic [SUM_W-1:0] sum_row;
    logic [CNT_W-1:0] count;
  } tbc_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tbc_q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_FINISH
  } tbc_back_state_t;

  // zero reads as one, anything above the maximum saturates
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
                                                 logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- src/tbc_fifo.sv -----
module tbc_fifo
  import tbc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tbc_item_t     push_item,
  input  logic          pop,
  output tbc_item_t     pop_item,
  output tbc_q_status_t status
);

  tbc_item_t          mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign status.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign status.empty = (count == '0);
  assign pop_item     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (mem_write_en(push)) begin
      mem[wr_ptr] <= push_item;
    end
  end

  function automatic logic mem_write_en(logic p);
    return p;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full) else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty) else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH)) else $error("queue fill count out of range");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + Q_CNT_W'(1))
    else $error("queue fill count missed a write");

endmodule

// ----- src/tbc_front.sv -----
module tbc_front
  import tbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LUMA_W-1:0]     pixel_luma,
  input  tbc_q_status_t         q_status,
  output logic                  push,
  output tbc_item_t             push_item
);

  logic [LUMA_W-1:0] luma_threshold;
  logic              track_dark;
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;

  logic [COL_W-1:0]  col_counter;
  logic [ROW_W-1:0]  row_counter;
  logic [SUM_W-1:0]  sum_col;
  logic [SUM_W-1:0]  sum_row;
  logic [CNT_W-1:0]  hit_count;

  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic              hit;
  logic              row_end;
  logic              last;
  logic [SUM_W-1:0]  sum_col_next;
  logic [SUM_W-1:0]  sum_row_next;
  logic [CNT_W-1:0]  hit_count_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_status.full;
  assign push      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      luma_threshold <= RST_LUMA_THRESHOLD;
      track_dark     <= 1'b0;
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LUMA_THRESHOLD: luma_threshold <= LUMA_W'(cfg_data);
        CFG_TRACK_DARK:     track_dark     <= cfg_data[0];
        CFG_IMAGE_WIDTH:    image_width    <= DIM_W'(cfg_data);
        CFG_IMAGE_HEIGHT:   image_height   <= DIM_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // classify the pixel, detect row and frame end, and form the queue item with the running sums
  always_comb begin
    w_eff = clamp_dim(image_width, DIM_W'(MAX_WIDTH));
    h_eff = clamp_dim(image_height, DIM_W'(MAX_HEIGHT));
    if (track_dark) begin
      hit = (pixel_luma <= luma_threshold);
    end else begin
      hit = (pixel_luma >= luma_threshold);
    end
    row_end = (DIM_W'(col_counter) >= (w_eff - DIM_W'(1)));
    last    = row_end && (DIM_W'(row_counter) >= (h_eff - DIM_W'(1)));

    sum_col_next   = sum_col;
    sum_row_next   = sum_row;
    hit_count_next = hit_count;
    if (hit) begin
      sum_col_next   = sum_col + SUM_W'(col_counter);
      sum_row_next   = sum_row + SUM_W'(row_counter);
      hit_count_next = hit_count + CNT_W'(1);
    end

    push_item.hit     = hit;
    push_item.col     = col_counter;
    push_item.row     = row_counter;
    push_item.last    = last;
    push_item.sum_col = sum_col_next;
    push_item.sum_row = sum_row_next;
    push_item.count   = hit_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_counter <= '0;
      row_counter <= '0;
      sum_col     <= '0;
      sum_row     <= '0;
      hit_count   <= '0;
    end else if (push) begin
      priority if (last) begin
        col_counter <= '0;
        row_counter <= '0;
        sum_col     <= '0;
        sum_row     <= '0;
        hit_count   <= '0;
      end else if (row_end) begin
        col_counter <= '0;
        row_counter <= row_counter + ROW_W'(1);
        sum_col     <= sum_col_next;
        sum_row     <= sum_row_next;
        hit_count   <= hit_count_next;
      end else begin
        col_counter <= col_counter + COL_W'(1);
        sum_col     <= sum_col_next;
        sum_row     <= sum_row_next;
        hit_count   <= hit_count_next;
      end
    end
  end

endmodule

// ----- src/tbc_back.sv -----
module tbc_back
  import tbc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  tbc_q_status_t    q_status,
  input  tbc_item_t        q_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             is_tracked,
  output logic [POS_W-1:0] pixel_col,
  output logic [POS_W-1:0] pixel_row,
  output logic             frame_done,
  output logic [POS_W-1:0] centroid_col,
  output logic [POS_W-1:0] centroid_row,
  output logic [CNT_W-1:0] tracked_count
);

  tbc_back_state_t        state;
  tbc_back_state_t        state_next;

  tbc_item_t              pend;
  logic [SUM_W-1:0]       dq_col;
  logic [SUM_W-1:0]       dq_row;
  logic [CNT_W-1:0]       rem_col;
  logic [CNT_W-1:0]       rem_row;
  logic [DIV_CNT_W-1:0]   step;

  logic                   out_free;
  logic                   load_plain;
  logic                   start_div;
  logic                   load_div;

  logic [CNT_W:0]         trial_col;
  logic [CNT_W:0]         trial_row;
  logic                   ge_col;
  logic                   ge_row;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_plain = 1'b0;
    start_div  = 1'b0;
    load_div   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          if (q_item.last && (q_item.count != '0)) begin
            pop        = 1'b1;
            start_div  = 1'b1;
            state_next = BK_DIVIDE;
          end else if (out_free) begin
            pop        = 1'b1;
            load_plain = 1'b1;
          end
        end
      end
      BK_DIVIDE: begin
        if (step == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (out_free) begin
          load_div   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // restoring division, both sums share the divisor
  always_comb begin
    trial_col = {rem_col, dq_col[SUM_W-1]};
    trial_row = {rem_row, dq_row[SUM_W-1]};
    ge_col    = (trial_col >= {1'b0, pend.count});
    ge_row    = (trial_row >= {1'b0, pend.count});
  end

  always_ff @(posedge clk) begin
    if (start_div) begin
      pend    <= q_item;
      dq_col  <= q_item.sum_col;
      dq_row  <= q_item.sum_row;
      rem_col <= '0;
      rem_row <= '0;
      step    <= '0;
    end else if (state == BK_DIVIDE) begin
      rem_col <= ge_col ? CNT_W'(trial_col - {1'b0, pend.count}) : CNT_W'(trial_col);
      rem_row <= ge_row ? CNT_W'(trial_row - {1'b0, pend.count}) : CNT_W'(trial_row);
      dq_col  <= {dq_col[SUM_W-2:0], ge_col};
      dq_row  <= {dq_row[SUM_W-2:0], ge_row};
      step    <= step + DIV_CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_plain || load_div) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_plain) begin
      is_tracked    <= q_item.hit;
      pixel_col     <= POS_W'(q_item.col);
      pixel_row     <= POS_W'(q_item.row);
      frame_done    <= q_item.last;
      centroid_col  <= '0;
      centroid_row  <= '0;
      tracked_count <= q_item.last ? q_item.count : '0;
    end else if (load_div) begin
      is_tracked    <= pend.hit;
      pixel_col     <= POS_W'(pend.col);
      pixel_row     <= POS_W'(pend.row);
      frame_done    <= 1'b1;
      centroid_col  <= POS_W'(dq_col);
      centroid_row  <= POS_W'(dq_row);
      tracked_count <= pend.count;
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DIVIDE) |-> (pend.count != '0))
    else $error("division started with a zero count");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == BK_FINISH) && $past(state == BK_DIVIDE)
      |-> $past(step) == DIV_CNT_W'(DIV_STEPS - 1))
    else $error("division left early");

  a_load_only_free: assert property (@(posedge clk) disable iff (rst)
    (load_plain || load_div) |-> out_free)
    else $error("result loaded over a waiting beat");

endmodule

// ----- src/threshold_blob_centroid_top.sv -----
// thresholded centroid tracker
// pixel channel: in_valid / in_stall with pixel_luma, one luma beat per pixel in
//   raster order; a beat is taken on a rising edge with in_valid high and in_stall low
// result channel: out_valid / out_stall, one beat per pixel carrying is_tracked,
//   pixel_col, pixel_row, frame_done, and on the frame's last pixel the centroid
//   and tracked_count (zero on every other beat)
// config channel: cfg_valid / cfg_ready, cfg_index picks the register
//   (threshold, track_dark, width, height), cfg_data holds the value; ready is
//   always high, unknown indices are dropped; write only while idle
// latency: two cycles from pixel beat to result beat for ordinary pixels
// throughput: one pixel per cycle; the last pixel of a frame with tracked pixels
//   holds the back end for 32 cycles: the pop, DIV_STEPS (30) divide cycles and a finish
// the four-deep queue between front end and back end soaks up part of that gap,
//   after which in_stall rises until the divider is done
// out_stall holds the output register; the back end stops popping and the
//   queue fills, then in_stall rises; nothing is dropped
// reset (rst, synchronous): registers back to defaults, counters, sums and queue
//   cleared, no result beat pending
module threshold_blob_centroid_top
  import tbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LUMA_W-1:0]     pixel_luma,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  is_tracked,
  output logic [POS_W-1:0]      pixel_col,
  output logic [POS_W-1:0]      pixel_row,
  output logic                  frame_done,
  output logic [POS_W-1:0]      centroid_col,
  output logic [POS_W-1:0]      centroid_row,
  output logic [CNT_W-1:0]      tracked_count
);

  // front to queue
  logic          push;
  tbc_item_t     push_item;

  // queue to back
  logic          pop;
  tbc_item_t     pop_item;
  tbc_q_status_t q_status;

  // front: config registers, threshold test, position counters, running sums
  tbc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_luma (pixel_luma),
    .q_status   (q_status),
    .push       (push),
    .push_item  (push_item)
  );

  // classified pixels, frame-end items carry the sum snapshot
  tbc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  // back: centroid division and the output register
  tbc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .q_item        (pop_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_tracked    (is_tracked),
    .pixel_col     (pixel_col),
    .pixel_row     (pixel_row),
    .frame_done    (frame_done),
    .centroid_col  (centroid_col),
    .centroid_row  (centroid_row),
    .tracked_count (tracked_count)
  );

endmodule
